[rtl/hufb_pkg.sv]
// Shared types and constants for the JPEG Huffman table build and decode block.
package hufb_pkg;

    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam int MAX_SYMBOLS_DEF     = 256;

    localparam int OP_W     = 3;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = 8;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int NEXT_W   = 17;
    localparam int FIDX_W   = 9;
    localparam int IDX_W    = FIDX_W + 1;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 3'd0,
        OP_COUNT  = 3'd1,
        OP_APPEND = 3'd2,
        OP_FINISH = 3'd3,
        OP_DECODE = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_SYMBOL      = 3'd1,
        ST_INVALID     = 3'd2,
        ST_NO_COUNT    = 3'd3,
        ST_NO_CODE     = 3'd4,
        ST_COUNTS_LEFT = 3'd5,
        ST_NOT_BUILT   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_TBL  = 2'd1,
        S_SYM  = 2'd2
    } t_state;

    // One entry of the per-length table.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  remain;
        logic [CODE_W-1:0] first_code;
        logic [FIDX_W-1:0] first_index;
    } t_len_entry;

endpackage

[rtl/hufb_len_tbl.sv]
// Per-length table memory with per-entry valid bits; invalid entries read as zero.
module hufb_len_tbl import hufb_pkg::*; #(
    parameter int DEPTH = MAX_CODE_LENGTH_DEF,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic [AW-1:0] i_raddr,
    output t_len_entry    o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_len_entry    i_wdata
);

    t_len_entry       mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_len_entry       r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[rtl/hufb_sym_store.sv]
// Symbol store: one write port, one registered read port, no reset.
module hufb_sym_store import hufb_pkg::*; #(
    parameter int DEPTH = MAX_SYMBOLS_DEF,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [SYM_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [SYM_W-1:0] o_rdata
);

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/jpeg_huffman_table_build_decode.sv]
// Top level: JPEG canonical Huffman table builder and bit-serial decoder.
//
// Builds a canonical JPEG Huffman code from per-length counts and a symbol
// list, then decodes one stream bit per beat. An item is taken when start is
// high and busy is low; every item yields exactly one result, shown for one
// cycle with o_valid high, and the receiver cannot hold it off. The result of
// an item appears in the cycle after its last work cycle. Start, finish, bad
// operation codes, count writes to an out-of-range length, append errors and
// decodes before the table is built finish without leaving idle (busy never
// rises); count writes to a valid length, appends and decode bits that do not
// yield a symbol also pass through the registered read of the per-length
// table (read-modify-write for builds, first-code lookup for decode), and a
// decode bit that hits a symbol then also reads the symbol store. The
// table state sits in a small per-length memory, cleared by valid bits at
// start-build, and a symbol memory that is never cleared and is read only at
// entries below the loaded count. Lengths with codes still to place are kept
// as a flag vector so the shortest free length is found combinationally.
module jpeg_huffman_table_build_decode import hufb_pkg::*; #(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [LEN_W-1:0]    i_length_index,
    input  logic [CNT_W-1:0]    i_length_count,
    input  logic [SYM_W-1:0]    i_symbol_value,
    input  logic                i_code_bit,
    output logic                o_valid,
    output logic [SYM_W-1:0]    o_decoded_symbol,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_matched_length
);

    localparam int LEN_AW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int SYM_AW = $clog2(MAX_SYMBOLS);
    localparam int NSYM_W = $clog2(MAX_SYMBOLS + 1);

    // control state
    t_state                     r_state, n_state;
    logic [NEXT_W-1:0]          r_next_code, n_next_code;
    logic [LEN_W-1:0]           r_build_len, n_build_len;
    logic [NSYM_W-1:0]          r_nsym, n_nsym;
    logic [CODE_W-1:0]          r_dec_code, n_dec_code;
    logic [LEN_W-1:0]           r_dec_len, n_dec_len;
    logic [LEN_W-1:0]           r_longest, n_longest;
    logic                       r_ready, n_ready;
    logic [MAX_CODE_LENGTH-1:0] r_rem_nz, n_rem_nz;   // lengths with codes left

    // pending item
    t_op                        r_op, n_op;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [SYM_W-1:0]           r_sym, n_sym;
    logic [NEXT_W-1:0]          r_pcode, n_pcode;
    logic [LEN_W-1:0]           r_plen, n_plen;

    // result beat
    logic                       r_o_valid, n_o_valid;
    logic [SYM_W-1:0]           r_o_sym, n_o_sym;
    t_status                    r_o_status, n_o_status;
    logic [LEN_W-1:0]           r_o_len, n_o_len;

    // memories
    logic [LEN_AW-1:0]          tbl_raddr, tbl_waddr;
    logic                       tbl_we, tbl_clr;
    t_len_entry                 tbl_rdata, tbl_wdata;
    logic                       sym_we;
    logic [SYM_AW-1:0]          sym_waddr, sym_raddr;
    logic [SYM_W-1:0]           sym_rdata;

    // append path
    logic                       scan_found;
    logic [LEN_AW-1:0]          scan_idx;
    logic [LEN_W-1:0]           app_len;
    logic [3:0]                 app_shift;
    logic [NEXT_W-1:0]          app_code;
    logic                       app_fits;
    logic                       nsym_full;

    // decode path
    logic [CNT_W-1:0]           dec_placed;
    logic [CODE_W-1:0]          dec_diff;
    logic                       dec_hit;
    logic [IDX_W-1:0]           dec_idx;
    logic                       dec_idx_ok;
    logic [LEN_AW-1:0]          upd_idx;

    hufb_len_tbl #(
        .DEPTH (MAX_CODE_LENGTH),
        .AW    (LEN_AW)
    ) u_len_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (tbl_clr),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata)
    );

    hufb_sym_store #(
        .DEPTH (MAX_SYMBOLS),
        .AW    (SYM_AW)
    ) u_sym_store (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (r_sym),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    // Shortest length at or above the build length that still has codes left.
    always_comb begin
        scan_found = 1'b0;
        scan_idx   = '0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            if (!scan_found && r_rem_nz[i] && (LEN_W'(i + 1) >= r_build_len)) begin
                scan_found = 1'b1;
                scan_idx   = LEN_AW'(i);
            end
        end
    end

    assign app_len   = LEN_W'(scan_idx) + LEN_W'(1);
    assign app_shift = 4'(app_len - r_build_len);
    assign app_code  = NEXT_W'(r_next_code << app_shift);
    assign app_fits  = (app_code >> app_len) == '0;
    assign nsym_full = r_nsym >= NSYM_W'(MAX_SYMBOLS);

    // decode compare against the entry read for the candidate length
    assign dec_placed = tbl_rdata.count - tbl_rdata.remain;
    assign dec_diff   = r_pcode[CODE_W-1:0] - tbl_rdata.first_code;
    assign dec_hit    = (dec_placed != '0) && (r_pcode[CODE_W-1:0] >= tbl_rdata.first_code)
                        && (dec_diff < CODE_W'(dec_placed));
    assign dec_idx    = IDX_W'(tbl_rdata.first_index) + IDX_W'(dec_diff[CNT_W-1:0]);
    assign dec_idx_ok = (dec_idx < IDX_W'(r_nsym)) && (dec_idx < IDX_W'(MAX_SYMBOLS));
    assign upd_idx    = LEN_AW'(r_plen - LEN_W'(1));

    always_comb begin
        t_len_entry ent;
        ent         = tbl_rdata;

        n_state     = r_state;
        n_next_code = r_next_code;
        n_build_len = r_build_len;
        n_nsym      = r_nsym;
        n_dec_code  = r_dec_code;
        n_dec_len   = r_dec_len;
        n_longest   = r_longest;
        n_ready     = r_ready;
        n_rem_nz    = r_rem_nz;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_sym       = r_sym;
        n_pcode     = r_pcode;
        n_plen      = r_plen;

        n_o_valid   = 1'b0;
        n_o_sym     = '0;
        n_o_status  = ST_OK;
        n_o_len     = '0;

        tbl_raddr   = '0;
        tbl_clr     = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = upd_idx;
        tbl_wdata   = tbl_rdata;
        sym_we      = 1'b0;
        sym_waddr   = r_nsym[SYM_AW-1:0];
        sym_raddr   = dec_idx[SYM_AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = t_op'(i_operation);
                    n_cnt = i_length_count;
                    n_sym = i_symbol_value;
                    unique case (t_op'(i_operation))
                        OP_START: begin
                            tbl_clr     = 1'b1;
                            n_rem_nz    = '0;
                            n_next_code = '0;
                            n_build_len = LEN_W'(1);
                            n_nsym      = '0;
                            n_longest   = '0;
                            n_ready     = 1'b0;
                            n_dec_code  = '0;
                            n_dec_len   = '0;
                            n_o_valid   = 1'b1;
                        end
                        OP_COUNT: begin
                            n_ready    = 1'b0;
                            n_dec_code = '0;
                            n_dec_len  = '0;
                            if (i_length_index >= LEN_W'(1) &&
                                i_length_index <= LEN_W'(MAX_CODE_LENGTH)) begin
                                tbl_raddr = LEN_AW'(i_length_index - LEN_W'(1));
                                n_plen    = i_length_index;
                                n_state   = S_TBL;
                            end else begin
                                n_o_valid = 1'b1;
                            end
                        end
                        OP_APPEND: begin
                            n_ready    = 1'b0;
                            n_dec_code = '0;
                            n_dec_len  = '0;
                            if (!scan_found) begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_NO_COUNT;
                            end else begin
                                n_next_code = app_code;
                                n_build_len = app_len;
                                if (!app_fits || nsym_full) begin
                                    n_o_valid  = 1'b1;
                                    n_o_status = ST_NO_CODE;
                                end else begin
                                    tbl_raddr = scan_idx;
                                    n_plen    = app_len;
                                    n_pcode   = app_code;
                                    n_state   = S_TBL;
                                end
                            end
                        end
                        OP_FINISH: begin
                            n_dec_code = '0;
                            n_dec_len  = '0;
                            n_o_valid  = 1'b1;
                            if (|r_rem_nz) begin
                                n_ready    = 1'b0;
                                n_o_status = ST_COUNTS_LEFT;
                            end else begin
                                n_ready = 1'b1;
                            end
                        end
                        OP_DECODE: begin
                            if (!r_ready) begin
                                n_dec_code = '0;
                                n_dec_len  = '0;
                                n_o_valid  = 1'b1;
                                n_o_status = ST_NOT_BUILT;
                            end else begin
                                // decode length stays below the longest length
                                n_pcode   = NEXT_W'({r_dec_code[CODE_W-2:0], i_code_bit});
                                n_plen    = r_dec_len + LEN_W'(1);
                                tbl_raddr = LEN_AW'(r_dec_len);
                                n_state   = S_TBL;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_TBL: begin
                n_state = S_IDLE;
                case (r_op)
                    OP_COUNT: begin
                        ent.count        = r_cnt;
                        ent.remain       = r_cnt;
                        tbl_we           = 1'b1;
                        tbl_wdata        = ent;
                        n_rem_nz[upd_idx] = r_cnt != '0;
                        n_o_valid        = 1'b1;
                    end
                    OP_APPEND: begin
                        if (tbl_rdata.remain == tbl_rdata.count) begin
                            ent.first_code  = r_pcode[CODE_W-1:0];
                            ent.first_index = FIDX_W'(r_nsym);
                        end
                        ent.remain        = tbl_rdata.remain - CNT_W'(1);
                        tbl_we            = 1'b1;
                        tbl_wdata         = ent;
                        n_rem_nz[upd_idx] = tbl_rdata.remain != CNT_W'(1);
                        sym_we            = 1'b1;
                        n_nsym            = r_nsym + NSYM_W'(1);
                        n_next_code       = r_pcode + NEXT_W'(1);
                        n_longest         = r_plen;
                        n_o_valid         = 1'b1;
                    end
                    default: begin
                        // decode: compare, then fetch the symbol on a hit
                        if (dec_hit) begin
                            n_dec_code = '0;
                            n_dec_len  = '0;
                            if (dec_idx_ok) begin
                                n_state = S_SYM;
                            end else begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_INVALID;
                            end
                        end else if (r_plen >= r_longest ||
                                     r_plen >= LEN_W'(MAX_CODE_LENGTH)) begin
                            n_dec_code = '0;
                            n_dec_len  = '0;
                            n_o_valid  = 1'b1;
                            n_o_status = ST_INVALID;
                        end else begin
                            n_dec_code = r_pcode[CODE_W-1:0];
                            n_dec_len  = r_plen;
                            n_o_valid  = 1'b1;
                        end
                    end
                endcase
            end

            S_SYM: begin
                n_state    = S_IDLE;
                n_o_valid  = 1'b1;
                n_o_status = ST_SYMBOL;
                n_o_sym    = sym_rdata;
                n_o_len    = r_plen;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_code <= '0;
            r_build_len <= LEN_W'(1);
            r_nsym      <= '0;
            r_dec_code  <= '0;
            r_dec_len   <= '0;
            r_longest   <= '0;
            r_ready     <= 1'b0;
            r_rem_nz    <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_code <= n_next_code;
            r_build_len <= n_build_len;
            r_nsym      <= n_nsym;
            r_dec_code  <= n_dec_code;
            r_dec_len   <= n_dec_len;
            r_longest   <= n_longest;
            r_ready     <= n_ready;
            r_rem_nz    <= n_rem_nz;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cnt      <= n_cnt;
        r_sym      <= n_sym;
        r_pcode    <= n_pcode;
        r_plen     <= n_plen;
        r_o_sym    <= n_o_sym;
        r_o_status <= n_o_status;
        r_o_len    <= n_o_len;
    end

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_o_valid;
    assign o_decoded_symbol = r_o_sym;
    assign o_status         = r_o_status;
    assign o_matched_length = r_o_len;

endmodule

[rtl/hufb_chk.sv]
// Port-level checker for the Huffman build/decode block, bound to the top level.
module hufb_chk import hufb_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic [SYM_W-1:0]    o_decoded_symbol,
    input logic [STATUS_W-1:0] o_status,
    input logic [LEN_W-1:0]    o_matched_length
);

    logic acc;
    assign acc = start && !busy;

    // every result beat follows an accepted item, directly or after the table and symbol reads
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(acc) || $past(acc, 2) || $past(acc, 3)))
        else $error("result beat without a recent item");

    // busy never stays high longer than the table and symbol reads of a decode hit
    a_busy_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |=> !busy)
        else $error("busy held too long");

    // symbol and length are zero unless a symbol is reported
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_SYMBOL)) |-> (o_decoded_symbol == '0 &&
                                                  o_matched_length == '0))
        else $error("symbol fields set on a non-symbol result");

    // a decoded symbol always carries a nonzero code length of at most 16
    a_symbol_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SYMBOL)) |-> (o_matched_length != '0 &&
                                                  o_matched_length <= LEN_W'(16)))
        else $error("symbol reported with bad length");

    // busy rises only right after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy)) |-> $past(acc))
        else $error("busy rose without an accepted item");

endmodule

bind jpeg_huffman_table_build_decode hufb_chk u_hufb_chk (.*);

[bench/tb_top.sv]
// Self-checking bench for the JPEG Huffman table build and bit-serial decode block.
module tb_top;
    import hufb_pkg::*;

    localparam int MAX_LEN  = MAX_CODE_LENGTH_DEF;
    localparam int MAX_SYMS = MAX_SYMBOLS_DEF;

    // Operation codes the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_BEATS = 1450;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic [SYM_W-1:0]    sym;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
    } t_huff_res;

    // One row of the directed table; want is used only when typed is set.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] li;
        logic [CNT_W-1:0] cnt;
        logic [SYM_W-1:0] sym;
        logic             cbit;
        logic             typed;
        t_huff_res        want;
    } t_dir_row;

    // A canonical code word of the table being built.
    typedef struct {
        logic [15:0] code;
        int          len;
    } t_code;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation = '0;
    logic [LEN_W-1:0]    i_length_index = '0;
    logic [CNT_W-1:0]    i_length_count = '0;
    logic [SYM_W-1:0]    i_symbol_value = '0;
    logic                i_code_bit = 1'b0;
    logic                o_valid;
    logic [SYM_W-1:0]    o_decoded_symbol;
    logic [STATUS_W-1:0] o_status;
    logic [LEN_W-1:0]    o_matched_length;

    // Typed expectation travels with the beat, so the monitor sees it at the
    // same edge as the inputs it belongs to.
    logic      typed_flag = 1'b0;
    t_huff_res typed_res = '0;

    jpeg_huffman_table_build_decode u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_length_index   (i_length_index),
        .i_length_count   (i_length_count),
        .i_symbol_value   (i_symbol_value),
        .i_code_bit       (i_code_bit),
        .o_valid          (o_valid),
        .o_decoded_symbol (o_decoded_symbol),
        .o_status         (o_status),
        .o_matched_length (o_matched_length)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the per-length table and symbol store.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  len_count       [MAX_LEN];
    logic [CNT_W-1:0]  len_left        [MAX_LEN];
    logic [15:0]       len_first_code  [MAX_LEN];
    logic [FIDX_W-1:0] len_first_index [MAX_LEN];
    logic [SYM_W-1:0]  sym_mem         [MAX_SYMS];
    logic [NEXT_W-1:0] next_code;
    int                build_len;
    int                n_loaded;
    int                longest;
    logic [15:0]       dec_code;
    int                dec_len;
    bit                ready;

    t_huff_res pending_res[$];
    int        n_mismatch = 0;
    int        n_beats = 0;
    int        quiet_left = 0;

    // Build plan for the current table: counts per length and its code words.
    int    plan_cnt [MAX_LEN];
    t_code plan_codes[$];

    function automatic void drop_prefix();
        dec_code = '0;
        dec_len  = 0;
    endfunction

    function automatic void clear_build();
        foreach (len_count[i]) begin
            len_count[i]       = '0;
            len_left[i]        = '0;
            len_first_code[i]  = '0;
            len_first_index[i] = '0;
        end
        next_code = '0;
        build_len = 1;
        n_loaded  = 0;
        longest   = 0;
        ready     = 1'b0;
        drop_prefix();
    endfunction

    // Canonical placement: shortest length with codes left, never shorter
    // than the length reached so far.
    function automatic logic [STATUS_W-1:0] place_symbol(input logic [SYM_W-1:0] sym);
        int                len;
        int                slot;
        logic [NEXT_W-1:0] code;
        len = build_len;
        while (len <= MAX_LEN && len_left[len-1] == 0)
            len++;
        if (len > MAX_LEN)
            return ST_NO_COUNT;
        code      = next_code << (len - build_len);
        next_code = code;
        build_len = len;
        if (code >= (NEXT_W'(1) << len) || n_loaded >= MAX_SYMS)
            return ST_NO_CODE;
        slot = len - 1;
        if (len_left[slot] == len_count[slot]) begin
            len_first_code[slot]  = code[15:0];
            len_first_index[slot] = FIDX_W'(n_loaded);
        end
        len_left[slot]    = len_left[slot] - 1'b1;
        sym_mem[n_loaded] = sym;
        n_loaded++;
        next_code = code + 1'b1;
        longest   = len;
        return ST_OK;
    endfunction

    function automatic t_huff_res huff_predict(input logic [OP_W-1:0] op,
                                               input logic [LEN_W-1:0] li,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [SYM_W-1:0] sym,
                                               input logic cbit);
        t_huff_res   res;
        logic [15:0] code;
        int          len, slot, placed, off, idx;
        bit          any_left;
        res = '0;
        case (op)
            OP_START: clear_build();
            OP_COUNT: begin
                ready = 1'b0;
                drop_prefix();
                if (li >= 1 && li <= MAX_LEN) begin
                    len_count[li-1] = cnt;
                    len_left[li-1]  = cnt;
                end
            end
            OP_APPEND: begin
                ready = 1'b0;
                drop_prefix();
                res.status = place_symbol(sym);
            end
            OP_FINISH: begin
                any_left = 1'b0;
                foreach (len_left[i])
                    if (len_left[i] != 0)
                        any_left = 1'b1;
                drop_prefix();
                if (any_left) begin
                    ready      = 1'b0;
                    res.status = ST_COUNTS_LEFT;
                end else begin
                    ready = 1'b1;
                end
            end
            OP_DECODE: begin
                if (!ready) begin
                    drop_prefix();
                    res.status = ST_NOT_BUILT;
                end else begin
                    code     = {dec_code[14:0], cbit};
                    len      = dec_len + 1;
                    dec_code = code;
                    dec_len  = len;
                    slot     = len - 1;
                    placed   = int'(len_count[slot]) - int'(len_left[slot]);
                    off      = int'(code) - int'(len_first_code[slot]);
                    if (placed != 0 && off >= 0 && off < placed) begin
                        idx = int'(len_first_index[slot]) + off;
                        if (idx < n_loaded && idx < MAX_SYMS) begin
                            res.sym    = sym_mem[idx];
                            res.status = ST_SYMBOL;
                            res.len    = LEN_W'(len);
                        end else begin
                            res.status = ST_INVALID;
                        end
                        drop_prefix();
                    end
                    // no code can be this long: the prefix is dead
                    if (res.status == ST_OK && (len >= longest || len >= MAX_LEN)) begin
                        res.status = ST_INVALID;
                        drop_prefix();
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: results are checked first, then the beat taken at this edge
    // is predicted, so a result and a new beat on one edge stay in order.
    // ------------------------------------------------------------------
    task automatic flag_error(input string what, input t_huff_res want, input t_huff_res got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%s: expected sym=%02h status=%0d len=%0d, got sym=%02h status=%0d len=%0d",
                     what, want.sym, want.status, want.len, got.sym, got.status, got.len);
    endtask

    always @(posedge i_clk) begin
        t_huff_res got, want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{o_decoded_symbol, o_status, o_matched_length};
                if (pending_res.size() == 0) begin
                    flag_error("unexpected result", '0, got);
                end else begin
                    want = pending_res.pop_front();
                    if (got !== want)
                        flag_error("result mismatch", want, got);
                end
            end
            if (start && !busy) begin
                want = huff_predict(i_operation, i_length_index, i_length_count,
                                    i_symbol_value, i_code_bit);
                if (typed_flag)
                    want = typed_res;
                pending_res.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    // Mostly back-to-back or short gaps, a few long ones, and now and then a
    // stretch with no gaps at all.
    function automatic int idle_len();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet_left = $urandom_range(16, 64);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Present one beat and hold it until the block takes it. Start stays
    // high into the next beat when no gap follows.
    task automatic beat(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] li,
                        input logic [CNT_W-1:0] cnt, input logic [SYM_W-1:0] sym,
                        input logic cbit, input logic typed = 1'b0,
                        input t_huff_res want = '0);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_length_index <= li;
        i_length_count <= cnt;
        i_symbol_value <= sym;
        i_code_bit     <= cbit;
        typed_flag     <= typed;
        typed_res      <= want;
        do @(posedge i_clk); while (busy);
        n_beats++;
    endtask

    task automatic simple_beat(input logic [OP_W-1:0] op);
        beat(op, LEN_W'($urandom), CNT_W'($urandom), SYM_W'($urandom), 1'($urandom));
    endtask

    // Canonical code words of plan_cnt, shortest first.
    function automatic void plan_code_words();
        int code;
        plan_codes.delete();
        code = 0;
        for (int l = 1; l <= MAX_LEN; l++) begin
            for (int k = 0; k < plan_cnt[l-1]; k++) begin
                plan_codes.push_back('{code[15:0], l});
                code++;
            end
            code = code << 1;
        end
    endfunction

    // Random counts that respect the Kraft bound; about half the lengths
    // are left empty so longer codes show up too.
    function automatic int plan_counts(input int max_n);
        int free_codes, left, hi, total;
        free_codes = 1;
        left       = max_n;
        total      = 0;
        for (int l = 0; l < MAX_LEN; l++) begin
            free_codes = free_codes * 2;
            hi = free_codes < left ? free_codes : left;
            if (hi > 255)
                hi = 255;
            plan_cnt[l] = $urandom_range(0, 1) ? int'($urandom_range(0, hi)) : 0;
            free_codes -= plan_cnt[l];
            left       -= plan_cnt[l];
            total      += plan_cnt[l];
        end
        plan_code_words();
        return total;
    endfunction

    // Count writes in a rotated order, zero counts only now and then, with
    // a stray out-of-range length thrown in occasionally.
    task automatic load_counts();
        int first, l;
        first = $urandom_range(0, MAX_LEN - 1);
        for (int i = 0; i < MAX_LEN; i++) begin
            l = (first + i) % MAX_LEN;
            if (plan_cnt[l] != 0 || $urandom_range(0, 4) == 0)
                beat(OP_COUNT, LEN_W'(l + 1), CNT_W'(plan_cnt[l]), SYM_W'($urandom),
                     1'($urandom));
            if ($urandom_range(0, 19) == 0)
                beat(OP_COUNT, $urandom_range(0, 1) ? 5'd0 : LEN_W'($urandom_range(17, 31)),
                     CNT_W'($urandom), SYM_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic append_syms(input int n);
        for (int i = 0; i < n; i++)
            beat(OP_APPEND, LEN_W'($urandom), CNT_W'($urandom), SYM_W'($urandom),
                 1'($urandom));
    endtask

    // Decode stream: mostly whole code words, some random bit runs, and a
    // rare ignored operation in the middle of a prefix.
    task automatic send_codes(input int n);
        t_code cw;
        for (int i = 0; i < n; i++) begin
            if (plan_codes.size() != 0 && $urandom_range(0, 4) != 0) begin
                cw = plan_codes[$urandom_range(0, plan_codes.size() - 1)];
                for (int b = cw.len - 1; b >= 0; b--)
                    beat(OP_DECODE, LEN_W'($urandom), CNT_W'($urandom), SYM_W'($urandom),
                         cw.code[b]);
            end else begin
                repeat ($urandom_range(1, 4))
                    simple_beat(OP_DECODE);
            end
            if ($urandom_range(0, 19) == 0)
                simple_beat($urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI);
        end
    endtask

    task automatic good_build(input int max_n);
        int total;
        simple_beat(OP_START);
        total = plan_counts(max_n);
        load_counts();
        append_syms(total);
        simple_beat(OP_FINISH);
        send_codes($urandom_range(4, 30));
    endtask

    task automatic broken_build();
        int total, l;
        simple_beat(OP_START);
        total = plan_counts(12);
        case ($urandom_range(0, 3))
            0: begin    // too few symbols: counts left at finish
                load_counts();
                append_syms(total > 0 ? $urandom_range(0, total - 1) : 0);
            end
            1: begin    // too many symbols: no count left
                load_counts();
                append_syms(total + $urandom_range(1, 3));
            end
            2: begin    // count rewritten halfway through the symbols
                load_counts();
                append_syms(total / 2);
                beat(OP_COUNT, LEN_W'($urandom_range(1, MAX_LEN)),
                     CNT_W'($urandom_range(0, 4)), SYM_W'($urandom), 1'($urandom));
                append_syms($urandom_range(0, 4));
            end
            default: begin    // more codes than the length can hold
                l = $urandom_range(1, 3);
                beat(OP_COUNT, LEN_W'(l), CNT_W'((1 << l) + $urandom_range(1, 3)),
                     SYM_W'($urandom), 1'($urandom));
                append_syms((1 << l) + 3);
            end
        endcase
        simple_beat(OP_FINISH);
        send_codes($urandom_range(3, 12));
    endtask

    // Full store: 255 nine-bit codes and one ten-bit code, then one symbol
    // too many for the store, then the table is repaired and decoded.
    task automatic full_store();
        simple_beat(OP_START);
        foreach (plan_cnt[i])
            plan_cnt[i] = 0;
        plan_cnt[8] = 255;
        plan_cnt[9] = 1;
        beat(OP_COUNT, 5'd9, 8'd255, SYM_W'($urandom), 1'($urandom));
        beat(OP_COUNT, 5'd10, 8'd1, SYM_W'($urandom), 1'($urandom));
        beat(OP_COUNT, 5'd16, 8'd1, SYM_W'($urandom), 1'($urandom));
        append_syms(MAX_SYMS + 1);
        simple_beat(OP_FINISH);
        beat(OP_COUNT, 5'd16, 8'd0, SYM_W'($urandom), 1'($urandom));
        simple_beat(OP_FINISH);
        plan_code_words();
        send_codes(40);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(8, 30))
            beat(OP_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 31)),
                 CNT_W'($urandom), SYM_W'($urandom), 1'($urandom));
    endtask

    // Directed part. Rows with typed set carry their result; the rest are
    // left to the predictor.
    t_dir_row dir_rows [24] = '{
        // nothing built yet
        '{OP_DECODE, 5'd3, 8'h81, 8'h42, 1'b1, 1'b1, '{8'h00, ST_NOT_BUILT, 5'd0}},
        // empty table: finish is fine, and every first bit is invalid
        '{OP_FINISH, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_DECODE, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_INVALID, 5'd0}},
        // unused operation codes are ignored
        '{OP_UNUSED_LO, 5'd31, 8'hff, 8'hff, 1'b1, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_UNUSED_HI, 5'd16, 8'h7e, 8'h81, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        // one code of length 1, one of length 16
        '{OP_START, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_COUNT, 5'd0, 8'hff, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_COUNT, 5'd31, 8'haa, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_COUNT, 5'd1, 8'd1, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_COUNT, 5'd16, 8'd1, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_APPEND, 5'd0, 8'h00, 8'hff, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_APPEND, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_APPEND, 5'd0, 8'h00, 8'h5a, 1'b0, 1'b1, '{8'h00, ST_NO_COUNT, 5'd0}},
        '{OP_FINISH, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_DECODE, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'hff, ST_SYMBOL, 5'd1}},
        '{OP_DECODE, 5'd0, 8'h00, 8'h00, 1'b1, 1'b0, '0},
        '{OP_DECODE, 5'd0, 8'h00, 8'h00, 1'b0, 1'b0, '0},
        // three codes asked of length 1: the third has no free code
        '{OP_START, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_COUNT, 5'd1, 8'd3, 8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 5'd0}},
        '{OP_APPEND, 5'd0, 8'h00, 8'h11, 1'b0, 1'b0, '0},
        '{OP_APPEND, 5'd0, 8'h00, 8'h22, 1'b0, 1'b0, '0},
        '{OP_APPEND, 5'd0, 8'h00, 8'h33, 1'b0, 1'b1, '{8'h00, ST_NO_CODE, 5'd0}},
        '{OP_FINISH, 5'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{8'h00, ST_COUNTS_LEFT, 5'd0}},
        '{OP_DECODE, 5'd0, 8'h00, 8'h00, 1'b1, 1'b1, '{8'h00, ST_NOT_BUILT, 5'd0}}
    };

    initial begin
        int full_at, scen, n_dir;
        clear_build();
        foreach (sym_mem[i])
            sym_mem[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            beat(dir_rows[i].op, dir_rows[i].li, dir_rows[i].cnt, dir_rows[i].sym,
                 dir_rows[i].cbit, dir_rows[i].typed, dir_rows[i].want);
        n_dir = n_beats;

        // Random part: mostly well-formed builds with decode streams, the rest
        // broken builds and raw noise; one full-store build early on.
        full_at = $urandom_range(0, 3);
        scen    = 0;
        while (n_beats < n_dir + RANDOM_BEATS) begin
            if (scen == full_at)
                full_store();
            else if ($urandom_range(0, 99) < 65)
                good_build($urandom_range(0, 9) == 0 ? 64 : 16);
            else if ($urandom_range(0, 1) == 0)
                broken_build();
            else
                noise_burst();
            scen++;
        end
        start <= 1'b0;

        // drain: wait until every expected result has been seen
        @(posedge i_clk);
        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
